// ===== hw/rtl/rmo_pkg.sv =====
`default_nettype none

package rmo_pkg;

   localparam int CHANNEL_BITS_DEFAULT = 24;
   localparam int COEF_BITS_DEFAULT    = 16;
   localparam int FRAC_BITS_DEFAULT    = 12;

   localparam int NUM_LANES      = 4;
   localparam int LANE_STRIDE    = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_ROW0     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_ROW1     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_ROW2     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_ROW3     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFFSET_VECTOR = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORDER_MODE    = 3'd5;

   localparam logic [CSR_DATA_BITS-1:0] COEF_ROW0_RESET = 64'h0000_0000_0000_1000;
   localparam logic [CSR_DATA_BITS-1:0] COEF_ROW1_RESET = 64'h0000_0000_1000_0000;
   localparam logic [CSR_DATA_BITS-1:0] COEF_ROW2_RESET = 64'h0000_1000_0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] COEF_ROW3_RESET = 64'h1000_0000_0000_0000;

   localparam logic MODE_FORWARD = 1'b0;
   localparam logic MODE_INVERSE = 1'b1;

   typedef struct packed {
      logic [NUM_LANES-1:0][CSR_DATA_BITS-1:0] coef_row;
      logic [CSR_DATA_BITS-1:0]                offset_vector;
      logic                                    order_mode;
   } rmo_cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rmo_req_if.sv =====
`default_nettype none

interface rmo_req_if #(
   parameter int CHANNEL_BITS = rmo_pkg::CHANNEL_BITS_DEFAULT
) ();
   logic                           valid;
   logic                           ready;
   logic signed [CHANNEL_BITS-1:0] red_in;
   logic signed [CHANNEL_BITS-1:0] green_in;
   logic signed [CHANNEL_BITS-1:0] blue_in;
   logic signed [CHANNEL_BITS-1:0] alpha_in;
   logic                           end_of_frame;

   modport source (
      output valid, red_in, green_in, blue_in, alpha_in, end_of_frame,
      input  ready
   );
   modport sink (
      input  valid, red_in, green_in, blue_in, alpha_in, end_of_frame,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/rmo_rsp_if.sv =====
`default_nettype none

interface rmo_rsp_if #(
   parameter int CHANNEL_BITS = rmo_pkg::CHANNEL_BITS_DEFAULT
) ();
   logic                           valid;
   logic                           ready;
   logic signed [CHANNEL_BITS-1:0] red_out;
   logic signed [CHANNEL_BITS-1:0] green_out;
   logic signed [CHANNEL_BITS-1:0] blue_out;
   logic signed [CHANNEL_BITS-1:0] alpha_out;
   logic                           end_of_frame_out;
   logic                           saturated;

   modport source (
      output valid, red_out, green_out, blue_out, alpha_out, end_of_frame_out, saturated,
      input  ready
   );
   modport sink (
      input  valid, red_out, green_out, blue_out, alpha_out, end_of_frame_out, saturated,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/rmo_csr_if.sv =====
`default_nettype none

interface rmo_csr_if ();
   logic                                 valid;
   logic                                 ready;
   logic [rmo_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [rmo_pkg::CSR_DATA_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rmo_regs.sv =====
`default_nettype none

module rmo_regs (
   input  wire logic          clock,
   input  wire logic          reset,
   rmo_csr_if.sink            csr,
   output rmo_pkg::rmo_cfg_type cfg
);

   rmo_pkg::rmo_cfg_type cfg_ff;
   rmo_pkg::rmo_cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            rmo_pkg::REG_COEF_ROW0:     cfg_in.coef_row[0]   = csr.data;
            rmo_pkg::REG_COEF_ROW1:     cfg_in.coef_row[1]   = csr.data;
            rmo_pkg::REG_COEF_ROW2:     cfg_in.coef_row[2]   = csr.data;
            rmo_pkg::REG_COEF_ROW3:     cfg_in.coef_row[3]   = csr.data;
            rmo_pkg::REG_OFFSET_VECTOR: cfg_in.offset_vector = csr.data;
            rmo_pkg::REG_ORDER_MODE:    cfg_in.order_mode    = csr.data[0];
            default:                    cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_row[0]   <= rmo_pkg::COEF_ROW0_RESET;
         cfg_ff.coef_row[1]   <= rmo_pkg::COEF_ROW1_RESET;
         cfg_ff.coef_row[2]   <= rmo_pkg::COEF_ROW2_RESET;
         cfg_ff.coef_row[3]   <= rmo_pkg::COEF_ROW3_RESET;
         cfg_ff.offset_vector <= '0;
         cfg_ff.order_mode    <= rmo_pkg::MODE_FORWARD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rgba_matrix_offset_transform_core.sv =====
// RGBA matrix-plus-offset colour transform.
// Requests arrive on the req channel, one pixel of four signed fixed-point
// channels each, and leave on the rsp channel as transformed pixels in the
// same order, with the end-of-frame mark copied and a saturation flag.
// Both channels use valid/ready; a request moves when both are high.
// The csr channel writes the coefficient rows, the offset vector and the
// order mode; it is always ready and should be written only while idle.
// The datapath is four register stages: offset subtraction in inverse mode,
// sixteen multipliers, row sums plus offset addition in forward mode, then
// rounding and saturation. A request passes through the stages in that order
// and shows on rsp from the last one; one request can be accepted in every
// cycle while rsp ready is high, so the sustained rate is one pixel per clock.
// When the receiver holds rsp ready low, the pipeline fills and req ready
// falls only once every stage holds a request; nothing is lost or repeated.
// Reset clears the pipeline and loads the identity matrix, zero offsets
// and forward mode.
`default_nettype none

module rgba_matrix_offset_transform_core #(
   parameter int CHANNEL_BITS = rmo_pkg::CHANNEL_BITS_DEFAULT,
   parameter int COEF_BITS    = rmo_pkg::COEF_BITS_DEFAULT,
   parameter int FRAC_BITS    = rmo_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   rmo_csr_if.sink   csr,
   rmo_req_if.sink   req,
   rmo_rsp_if.source rsp
);

   localparam int NL = rmo_pkg::NUM_LANES;
   localparam int XW = ((CHANNEL_BITS > COEF_BITS) ? CHANNEL_BITS : COEF_BITS) + 1;
   localparam int PW = XW + COEF_BITS;
   localparam int OW = COEF_BITS + FRAC_BITS;
   localparam int AW = ((PW > OW) ? PW : OW) + 3;
   localparam logic signed [AW-1:0] HALF   = AW'(1) << (FRAC_BITS - 1);
   localparam logic signed [AW-1:0] CH_MAX = (AW'(1) << (CHANNEL_BITS - 1)) - AW'(1);
   localparam logic signed [AW-1:0] CH_MIN = -CH_MAX - AW'(1);

   rmo_pkg::rmo_cfg_type cfg;

   rmo_regs u_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   logic signed [COEF_BITS-1:0] coef [NL][NL];
   logic signed [COEF_BITS-1:0] offs [NL];
   logic signed [CHANNEL_BITS-1:0] req_ch [NL];

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         offs[i] = cfg.offset_vector[rmo_pkg::LANE_STRIDE*i +: COEF_BITS];
         for (int j = 0; j < NL; j++) begin
            coef[i][j] = cfg.coef_row[i][rmo_pkg::LANE_STRIDE*j +: COEF_BITS];
         end
      end
   end

   assign req_ch[0] = req.red_in;
   assign req_ch[1] = req.green_in;
   assign req_ch[2] = req.blue_in;
   assign req_ch[3] = req.alpha_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4       = !v4_ff || rsp.ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req.ready = en1;

   logic signed [XW-1:0] x_ff [NL];
   logic signed [XW-1:0] x_in [NL];
   logic eof1_ff, eof2_ff, eof3_ff, eof4_ff;

   always_comb begin
      for (int j = 0; j < NL; j++) begin
         if (cfg.order_mode == rmo_pkg::MODE_INVERSE) begin
            x_in[j] = XW'(req_ch[j]) - XW'(offs[j]);
         end else begin
            x_in[j] = XW'(req_ch[j]);
         end
      end
   end

   logic signed [PW-1:0] p_ff [NL][NL];
   logic signed [PW-1:0] p_in [NL][NL];

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         for (int j = 0; j < NL; j++) begin
            p_in[i][j] = PW'(x_ff[j]) * PW'(coef[i][j]);
         end
      end
   end

   logic signed [AW-1:0] acc_ff [NL];
   logic signed [AW-1:0] acc_in [NL];

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         acc_in[i] = AW'(p_ff[i][0]) + AW'(p_ff[i][1]) + AW'(p_ff[i][2]) + AW'(p_ff[i][3]);
         if (cfg.order_mode == rmo_pkg::MODE_FORWARD) begin
            acc_in[i] = acc_in[i] + (AW'(offs[i]) << FRAC_BITS);
         end
      end
   end

   logic signed [CHANNEL_BITS-1:0] y_ff [NL];
   logic signed [CHANNEL_BITS-1:0] y_in [NL];
   logic [NL-1:0]                  clip;
   logic                           sat_ff;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         logic signed [AW-1:0] r;
         r = (acc_ff[i] + HALF) >>> FRAC_BITS;
         if (r > CH_MAX) begin
            y_in[i] = CH_MAX[CHANNEL_BITS-1:0];
            clip[i] = 1'b1;
         end else if (r < CH_MIN) begin
            y_in[i] = CH_MIN[CHANNEL_BITS-1:0];
            clip[i] = 1'b1;
         end else begin
            y_in[i] = r[CHANNEL_BITS-1:0];
            clip[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         x_ff    <= x_in;
         eof1_ff <= req.end_of_frame;
      end
      if (en2) begin
         p_ff    <= p_in;
         eof2_ff <= eof1_ff;
      end
      if (en3) begin
         acc_ff  <= acc_in;
         eof3_ff <= eof2_ff;
      end
      if (en4) begin
         y_ff    <= y_in;
         sat_ff  <= |clip;
         eof4_ff <= eof3_ff;
      end
   end

   assign rsp.valid            = v4_ff;
   assign rsp.red_out          = y_ff[0];
   assign rsp.green_out        = y_ff[1];
   assign rsp.blue_out         = y_ff[2];
   assign rsp.alpha_out        = y_ff[3];
   assign rsp.end_of_frame_out = eof4_ff;
   assign rsp.saturated        = sat_ff;

endmodule

`default_nettype wire
